// File: hw/rtl/bencode_tokenizer_assert.svh
// ---------------------------------------------------------------------------
// bencode tokenizer assertion macros
// concurrent checks, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef BENCODE_TOKENIZER_ASSERT_SVH
`define BENCODE_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define BT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/bt_pkg.sv
// ---------------------------------------------------------------------------
// bencode tokenizer package
// shared widths, character codes, token kinds and result record
// ---------------------------------------------------------------------------
package bt_pkg;

  // buffer offset counter width
  localparam int OffsetBits = 32;
  localparam int LenBits    = 32;

  // result queue
  localparam int Depth     = 4;
  localparam int PtrBits   = $clog2(Depth);
  localparam int CountBits = $clog2(Depth + 1);

  // character codes
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChI     = 8'h69;
  localparam logic [7:0] ChL     = 8'h6c;
  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChE     = 8'h65;

  typedef enum logic [2:0] {
    KIND_STRING = 3'd0,
    KIND_INT    = 3'd1,
    KIND_LIST   = 3'd2,
    KIND_DICT   = 3'd3,
    KIND_END    = 3'd4,
    KIND_ERROR  = 3'd5,
    KIND_DONE   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_LEN  = 2'd1,
    MODE_BODY = 2'd2,
    MODE_INT  = 2'd3
  } mode_t;

  typedef struct packed {
    kind_t         kind;
    logic [31:0]   start_offset;
    logic [31:0]   token_length;
    logic          last_of_run;
  } result_t;

endpackage

// File: hw/rtl/bt_if.sv
// ---------------------------------------------------------------------------
// bencode tokenizer channels
// valid/ready byte channel and token channel
// ---------------------------------------------------------------------------
interface bt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink (input valid, data_byte, end_of_buffer, output ready);
endinterface

interface bt_out_if;
  logic            valid;
  logic            ready;
  bt_pkg::kind_t   kind;
  logic [31:0]     start_offset;
  logic [31:0]     token_length;
  logic            last_of_run;

  modport source (output valid, kind, start_offset, token_length, last_of_run,
                  input ready);
  modport sink (input valid, kind, start_offset, token_length, last_of_run,
                output ready);
endinterface

// File: hw/rtl/bencode_tokenizer.sv
// ---------------------------------------------------------------------------
// bencode tokenizer
// streaming scanner: one byte in, up to two tokens out
// ---------------------------------------------------------------------------
// ordering: a token enters the result queue the cycle after its byte is taken
// throughput: one byte per cycle; input is held off while fewer than two of the
//   four queue entries are free, i.e. output stalled or two-token bytes arriving
//   faster than one token drains per cycle
// reset: synchronous, active high; scanner returns to idle at offset zero and
//   the result queue empties; each end-of-buffer byte resets only the scanner
`include "bencode_tokenizer_assert.svh"

module bencode_tokenizer (
  input  logic            clk,
  input  logic            rst,
  bt_in_if.sink           bytes,
  bt_out_if.source        tokens
);

  // scanner state
  bt_pkg::mode_t                      mode, mode_next;
  logic [bt_pkg::LenBits-1:0]         len_acc, len_acc_next;
  logic [bt_pkg::LenBits-1:0]         remaining, remaining_next;
  logic [bt_pkg::OffsetBits-1:0]      position, position_next;
  logic [bt_pkg::OffsetBits-1:0]      token_start, token_start_next;

  // result queue
  bt_pkg::result_t                    fifo [bt_pkg::Depth];
  logic [bt_pkg::PtrBits-1:0]         rd_ptr, wr_ptr;
  logic [bt_pkg::CountBits-1:0]       count;

  // per-byte decode
  logic                               accept, pop;
  logic [bt_pkg::OffsetBits-1:0]      next_pos;
  logic                               is_digit;
  logic [3:0]                         digit;
  logic [bt_pkg::LenBits+3:0]         prod;
  logic [bt_pkg::LenBits-1:0]         len_scaled;
  logic [bt_pkg::LenBits-1:0]         rem_dec;

  // token produced by this byte (done is separate)
  logic                               tok_valid;
  bt_pkg::kind_t                      tok_kind;
  logic [bt_pkg::OffsetBits-1:0]      tok_start;
  logic [bt_pkg::LenBits-1:0]         tok_len;

  bt_pkg::result_t                    ent_first, ent_second, ent_done;
  logic [1:0]                         push_n;

  assign accept = bytes.valid && bytes.ready;
  assign pop    = tokens.valid && tokens.ready;

  // take a byte only if both possible results fit
  assign bytes.ready = count < bt_pkg::CountBits'(bt_pkg::Depth - 1);

  assign next_pos = position + bt_pkg::OffsetBits'(1);
  assign digit    = bytes.data_byte[3:0];

  always_comb begin
    is_digit = bytes.data_byte inside {[bt_pkg::ChZero:bt_pkg::ChNine]};
  end

  // length * 10 + digit, saturating at all ones
  assign prod = {1'b0, len_acc, 3'b000} + {3'b000, len_acc, 1'b0}
              + {(bt_pkg::LenBits)'(0), digit};
  assign len_scaled = (prod[bt_pkg::LenBits+3:bt_pkg::LenBits] != 4'd0)
                    ? '1 : prod[bt_pkg::LenBits-1:0];

  assign rem_dec = (remaining != '0) ? remaining - bt_pkg::LenBits'(1) : remaining;

  // scanner next state and token
  always_comb begin
    mode_next        = mode;
    len_acc_next     = len_acc;
    remaining_next   = remaining;
    token_start_next = token_start;
    tok_valid        = 1'b0;
    tok_kind         = bt_pkg::KIND_ERROR;
    tok_start        = next_pos;
    tok_len          = '0;

    case (mode)
      bt_pkg::MODE_LEN: begin
        if (bytes.data_byte == bt_pkg::ChColon) begin
          if (len_acc == '0) begin
            // empty string completes on the colon
            tok_valid = 1'b1;
            tok_kind  = bt_pkg::KIND_STRING;
            mode_next = bt_pkg::MODE_IDLE;
          end else if (bytes.end_of_buffer) begin
            tok_valid = 1'b1;
          end else begin
            token_start_next = next_pos;
            remaining_next   = len_acc;
            mode_next        = bt_pkg::MODE_BODY;
          end
        end else if (is_digit) begin
          len_acc_next = len_scaled;
          tok_valid    = bytes.end_of_buffer;
        end else begin
          // junk inside the length: drop it, restart
          tok_valid = 1'b1;
          mode_next = bt_pkg::MODE_IDLE;
        end
      end
      bt_pkg::MODE_BODY: begin
        remaining_next = rem_dec;
        if (rem_dec == '0) begin
          tok_valid = 1'b1;
          tok_kind  = bt_pkg::KIND_STRING;
          tok_start = token_start;
          tok_len   = len_acc;
          mode_next = bt_pkg::MODE_IDLE;
        end else if (bytes.end_of_buffer) begin
          // buffer cut mid-string
          tok_valid = 1'b1;
        end
      end
      bt_pkg::MODE_INT: begin
        tok_kind  = bt_pkg::KIND_INT;
        tok_start = token_start;
        if (bytes.data_byte == bt_pkg::ChE) begin
          tok_valid = 1'b1;
          tok_len   = len_acc;
          mode_next = bt_pkg::MODE_IDLE;
        end else begin
          // forgiving integer text: count anything, saturating
          if (len_acc != '1) begin
            len_acc_next = len_acc + bt_pkg::LenBits'(1);
          end
          tok_valid = bytes.end_of_buffer;
          tok_len   = len_acc_next;
        end
      end
      default: begin
        // idle, awaiting token start
        mode_next = bt_pkg::MODE_IDLE;
        if (is_digit) begin
          len_acc_next = {(bt_pkg::LenBits-4)'(0), digit};
          mode_next    = bt_pkg::MODE_LEN;
          tok_valid    = bytes.end_of_buffer;
        end else if (bytes.data_byte == bt_pkg::ChI) begin
          len_acc_next     = '0;
          token_start_next = next_pos;
          mode_next        = bt_pkg::MODE_INT;
          tok_valid        = bytes.end_of_buffer;
          tok_kind         = bt_pkg::KIND_INT;
        end else if (bytes.data_byte == bt_pkg::ChL) begin
          tok_valid = 1'b1;
          tok_kind  = bt_pkg::KIND_LIST;
        end else if (bytes.data_byte == bt_pkg::ChD) begin
          tok_valid = 1'b1;
          tok_kind  = bt_pkg::KIND_DICT;
        end else if (bytes.data_byte == bt_pkg::ChE) begin
          tok_valid = 1'b1;
          tok_kind  = bt_pkg::KIND_END;
        end else begin
          tok_valid = 1'b1;
        end
      end
    endcase

    // end of buffer: back to reset state for the next buffer
    if (bytes.end_of_buffer) begin
      mode_next        = bt_pkg::MODE_IDLE;
      len_acc_next     = '0;
      remaining_next   = '0;
      token_start_next = '0;
      position_next    = '0;
    end else begin
      position_next    = next_pos;
    end
  end

  // queue entries: token first, then done on the final byte
  always_comb begin
    ent_done.kind         = bt_pkg::KIND_DONE;
    ent_done.start_offset = 32'(next_pos);
    ent_done.token_length = '0;
    ent_done.last_of_run  = 1'b1;

    ent_first.kind         = tok_kind;
    ent_first.start_offset = 32'(tok_start);
    ent_first.token_length = 32'(tok_len);
    ent_first.last_of_run  = !bytes.end_of_buffer;

    ent_second = ent_done;
    if (!tok_valid) begin
      ent_first = ent_done;
    end
    push_n = accept ? ({1'b0, tok_valid} + {1'b0, bytes.end_of_buffer}) : 2'd0;
  end

  // scanner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= bt_pkg::MODE_IDLE;
      len_acc     <= '0;
      remaining   <= '0;
      position    <= '0;
      token_start <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      len_acc     <= len_acc_next;
      remaining   <= remaining_next;
      position    <= position_next;
      token_start <= token_start_next;
    end
  end

  // result queue storage, no reset on payload
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[wr_ptr] <= ent_first;
    end
    if (push_n == 2'd2) begin
      fifo[wr_ptr + bt_pkg::PtrBits'(1)] <= ent_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + bt_pkg::PtrBits'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + bt_pkg::PtrBits'(1);
      end
      count <= count + bt_pkg::CountBits'(push_n) - bt_pkg::CountBits'(pop);
    end
  end

  // output from the head of the queue
  assign tokens.valid        = count != '0;
  assign tokens.kind         = fifo[rd_ptr].kind;
  assign tokens.start_offset = fifo[rd_ptr].start_offset;
  assign tokens.token_length = fifo[rd_ptr].token_length;
  assign tokens.last_of_run  = fifo[rd_ptr].last_of_run;

  // checks
  `BT_ASSERT_IMPLIES(a_queue_bound, clk, rst, 1'b1,
    count <= bt_pkg::CountBits'(bt_pkg::Depth), "result queue overflow")
  `BT_ASSERT_NEXT(a_eob_resets, clk, rst, accept && bytes.end_of_buffer,
    mode == bt_pkg::MODE_IDLE && position == '0, "scanner not reset after buffer end")
  `BT_ASSERT_NEXT(a_eob_queues_done, clk, rst, accept && bytes.end_of_buffer,
    count != '0, "done not queued after buffer end")

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// bencode tokenizer testbench
// directed and random byte buffers, token checking by a predicting scoreboard
// ----------------------------------------------------------------------------
module tb_top;

  // scoreboard: predicts tokens per accepted byte, checks tokens in order
  class token_scoreboard;
    bt_pkg::mode_t   scan_mode;
    logic [31:0]     len_acc;
    logic [31:0]     body_left;
    logic [31:0]     offset;
    logic [31:0]     content_start;
    bt_pkg::result_t expected_tokens[$];
    int              mismatches;

    function new();
      mismatches = 0;
      clear_scan();
    endfunction

    // same state as after reset or an end-of-buffer byte
    function void clear_scan();
      scan_mode     = bt_pkg::MODE_IDLE;
      len_acc       = 32'd0;
      body_left     = 32'd0;
      offset        = 32'd0;
      content_start = 32'd0;
    endfunction

    function bt_pkg::result_t make_token(bt_pkg::kind_t k, logic [31:0] s,
                                         logic [31:0] l);
      bt_pkg::result_t t;
      t.kind         = k;
      t.start_offset = s;
      t.token_length = l;
      t.last_of_run  = 1'b0;
      return t;
    endfunction

    function void note_byte(logic [7:0] b, logic eob);
      logic [31:0]     next_off;
      logic            digit;
      logic [35:0]     grown;
      bt_pkg::result_t run[$];
      bt_pkg::result_t tok;
      next_off = offset + 32'd1;
      digit    = (b >= bt_pkg::ChZero) && (b <= bt_pkg::ChNine);
      case (scan_mode)
        bt_pkg::MODE_LEN: begin
          if (b == bt_pkg::ChColon) begin
            if (len_acc == 32'd0) begin
              run.push_back(make_token(bt_pkg::KIND_STRING, next_off, 32'd0));
              scan_mode = bt_pkg::MODE_IDLE;
            end else if (eob) begin
              run.push_back(make_token(bt_pkg::KIND_ERROR, next_off, 32'd0));
            end else begin
              content_start = next_off;
              body_left     = len_acc;
              scan_mode     = bt_pkg::MODE_BODY;
            end
          end else if (digit) begin
            // saturate at all ones
            grown   = {4'd0, len_acc} * 36'd10 + {28'd0, b - bt_pkg::ChZero};
            len_acc = (grown > 36'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
            if (eob) run.push_back(make_token(bt_pkg::KIND_ERROR, next_off, 32'd0));
          end else begin
            run.push_back(make_token(bt_pkg::KIND_ERROR, next_off, 32'd0));
            scan_mode = bt_pkg::MODE_IDLE;
          end
        end
        bt_pkg::MODE_BODY: begin
          if (body_left != 32'd0) body_left = body_left - 32'd1;
          if (body_left == 32'd0) begin
            run.push_back(make_token(bt_pkg::KIND_STRING, content_start, len_acc));
            scan_mode = bt_pkg::MODE_IDLE;
          end else if (eob) begin
            run.push_back(make_token(bt_pkg::KIND_ERROR, next_off, 32'd0));
          end
        end
        bt_pkg::MODE_INT: begin
          if (b == bt_pkg::ChE) begin
            run.push_back(make_token(bt_pkg::KIND_INT, content_start, len_acc));
            scan_mode = bt_pkg::MODE_IDLE;
          end else begin
            if (len_acc != 32'hFFFF_FFFF) len_acc = len_acc + 32'd1;
            if (eob) run.push_back(make_token(bt_pkg::KIND_INT, content_start, len_acc));
          end
        end
        default: begin
          scan_mode = bt_pkg::MODE_IDLE;
          if (digit) begin
            len_acc   = {24'd0, b - bt_pkg::ChZero};
            scan_mode = bt_pkg::MODE_LEN;
            if (eob) run.push_back(make_token(bt_pkg::KIND_ERROR, next_off, 32'd0));
          end else if (b == bt_pkg::ChI) begin
            len_acc       = 32'd0;
            content_start = next_off;
            scan_mode     = bt_pkg::MODE_INT;
            if (eob) run.push_back(make_token(bt_pkg::KIND_INT, next_off, 32'd0));
          end else if (b == bt_pkg::ChL) begin
            run.push_back(make_token(bt_pkg::KIND_LIST, next_off, 32'd0));
          end else if (b == bt_pkg::ChD) begin
            run.push_back(make_token(bt_pkg::KIND_DICT, next_off, 32'd0));
          end else if (b == bt_pkg::ChE) begin
            run.push_back(make_token(bt_pkg::KIND_END, next_off, 32'd0));
          end else begin
            run.push_back(make_token(bt_pkg::KIND_ERROR, next_off, 32'd0));
          end
        end
      endcase
      if (eob) begin
        run.push_back(make_token(bt_pkg::KIND_DONE, next_off, 32'd0));
        clear_scan();
      end else begin
        offset = next_off;
      end
      foreach (run[i]) begin
        tok             = run[i];
        tok.last_of_run = (i == run.size() - 1);
        expected_tokens.push_back(tok);
      end
    endfunction

    function void check_token(bt_pkg::result_t got);
      bt_pkg::result_t want;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("token with none expected: kind %0d start %0d length %0d last %0b",
                   got.kind, got.start_offset, got.token_length, got.last_of_run);
        return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind || got.start_offset !== want.start_offset ||
          got.token_length !== want.token_length ||
          got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= 10)
          $display("token mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                   want.kind, want.start_offset, want.token_length, want.last_of_run,
                   got.kind, got.start_offset, got.token_length, got.last_of_run);
      end
    endfunction
  endclass

  localparam int ByteTarget = 1100;  // random part stops once this many bytes are in
  localparam int HoldAt     = 500;   // byte count that triggers the long hold-off
  localparam int HoldCycles = 60;
  localparam int TimeLimit  = 4_800_000;

  logic clk = 1'b0;
  logic rst;

  bt_in_if  in_ch ();
  bt_out_if out_ch ();

  bencode_tokenizer DUT (
    .clk    (clk),
    .rst    (rst),
    .bytes  (in_ch),
    .tokens (out_ch)
  );

  token_scoreboard tokens_sb = new();

  logic [7:0] msg_bytes[$];   // buffer being built for the byte channel
  int         bytes_sent = 0;
  bit         calm_tx = 1'b0; // no gaps on the byte side for this buffer
  bit         calm_rx = 1'b0; // no stalls on the token side for a while
  bit         hold_req = 1'b0;
  bit         hold_on = 1'b0;

  // 12 unit period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 45) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 24));
  endfunction

  // offer one byte, wait for the transaction, then tell the scoreboard
  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    gap = hold_on ? 0 : pick_gap(calm_tx);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_buffer <= eob;
    // ready as it stood at the edge
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tokens_sb.note_byte(b, eob);
    bytes_sent++;
    if (bytes_sent == HoldAt) hold_req = 1'b1;
  endtask

  // text as bytes; end-of-buffer flag on the final character if asked
  task automatic send_text(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], ends && (i == s.len() - 1));
  endtask

  task automatic send_message();
    calm_tx = ($urandom_range(0, 4) == 0);
    foreach (msg_bytes[i])
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  function automatic logic [7:0] rand_digit();
    return bt_pkg::ChZero + 8'($urandom_range(0, 9));
  endfunction

  // random buffer: well-formed tokens mostly, with noise and truncation
  function automatic void build_message();
    int    count;
    int    r;
    int    len;
    string len_text;
    logic [7:0] b;
    msg_bytes.delete();
    if ($urandom_range(0, 19) == 0) begin
      // pure noise
      count = int'($urandom_range(3, 12));
      repeat (count) msg_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    count = int'($urandom_range(1, 8));
    repeat (count) begin
      r = int'($urandom_range(0, 99));
      if (r < 35) begin
        // string, now and then a long body or a leading zero
        len = ($urandom_range(0, 32) == 0) ? int'($urandom_range(60, 200))
                                          : int'($urandom_range(0, 10));
        if ($urandom_range(0, 9) == 0) msg_bytes.push_back(bt_pkg::ChZero);
        len_text = $sformatf("%0d", len);
        for (int i = 0; i < len_text.len(); i++) msg_bytes.push_back(len_text[i]);
        msg_bytes.push_back(bt_pkg::ChColon);
        repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 55) begin
        // integer: digits with optional sign, or loose bytes other than 'e'
        msg_bytes.push_back(bt_pkg::ChI);
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(0, 4)) begin
            do b = 8'($urandom_range(0, 255)); while (b == bt_pkg::ChE);
            msg_bytes.push_back(b);
          end
        end else begin
          if ($urandom_range(0, 6) == 0) msg_bytes.push_back(8'h2d);
          repeat ($urandom_range(0, 5)) msg_bytes.push_back(rand_digit());
        end
        msg_bytes.push_back(bt_pkg::ChE);
      end else if (r < 65) begin
        msg_bytes.push_back(bt_pkg::ChL);
      end else if (r < 75) begin
        msg_bytes.push_back(bt_pkg::ChD);
      end else if (r < 85) begin
        msg_bytes.push_back(bt_pkg::ChE);
      end else if (r < 90) begin
        // overlong length field, then any byte; the buffer end bounds a long body
        repeat ($urandom_range(10, 12)) msg_bytes.push_back(rand_digit());
        msg_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        msg_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    // cut short inside some token
    if ($urandom_range(0, 4) == 0) begin
      len = int'($urandom_range(1, msg_bytes.size()));
      while (msg_bytes.size() > len) void'(msg_bytes.pop_back());
    end
  endfunction

  // token side: random stalls, calm stretches, and one long hold-off
  initial begin : drive_ready
    int stall;
    int rounds;
    out_ch.ready = 1'b0;
    rounds = 0;
    wait (rst === 1'b0);
    forever begin
      if (hold_req) begin
        // hold off long enough for the result queue to fill
        @(negedge clk);
        out_ch.ready <= 1'b0;
        hold_on = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_on  = 1'b0;
        hold_req = 1'b0;
      end
      rounds++;
      if (rounds % 50 == 0) calm_rx = ($urandom_range(0, 3) == 0);
      stall = pick_gap(calm_rx);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
    end
  end

  // check every token transaction against the oldest expectation
  always @(posedge clk) begin : watch_tokens
    bt_pkg::result_t seen;
    if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.kind         = out_ch.kind;
      seen.start_offset = out_ch.start_offset;
      seen.token_length = out_ch.token_length;
      seen.last_of_run  = out_ch.last_of_run;
      tokens_sb.check_token(seen);
    end
  end

  // run limit
  initial begin
    #(TimeLimit);
    $display("Verification failed");
    $finish;
  end

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = 8'd0;
    in_ch.end_of_buffer = 1'b0;
    rst                 = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty string, list, dict, end, bad start bytes at both
    // extremes, non-digit inside a length, buffer ending in integer text
    send_text("0:lde", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("3xi7", 1'b1);
    // saturating length, then a colon as the final byte
    send_text("99999999999:", 1'b1);
    // final byte is a lone 'i'
    send_text("i", 1'b1);
    // buffer ends inside a string body
    send_text("2:a", 1'b1);

    // random buffers
    while (bytes_sent < ByteTarget) begin
      build_message();
      send_message();
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // drain, then let the pipeline settle
    while (tokens_sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (tokens_sb.mismatches == 0 && tokens_sb.expected_tokens.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
